// ----- src/mf3_pkg.sv -----
// shared constants and types of the 3x3 median filter
`timescale 1ns / 1ps

package mf3_pkg;

	localparam int MAX_SIZE_DEF   = 128;
	localparam int PIXEL_BITS_DEF = 8;
	localparam int QUEUE_DEPTH    = 4;
	localparam int WIN_TAPS       = 9;

	localparam int SIZE_BITS = 8;
	localparam logic [SIZE_BITS-1:0] SIZE_RESET = 8'd128;

	// register map: one register, byte address 4*i
	localparam int ADDR_BITS = 3;
	localparam logic [ADDR_BITS-3:0] REG_IMAGE_SIZE = 1'b0;

	typedef struct packed {
		logic                 restart;
		logic [SIZE_BITS-1:0] size;
	} mf3_cfg_t;

endpackage

// ----- src/mf3_queue.sv -----
// short first-in first-out queue between the front and the sorter
`timescale 1ns / 1ps

module mf3_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [W-1:0] wr_data,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] rd_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/mf3_front.sv -----
// front: position counters, line buffers and the 3x3 window
`timescale 1ns / 1ps

module mf3_front #(
	parameter int MAX_SIZE   = 128,
	parameter int PIXEL_BITS = 8,
	parameter int CW         = $clog2(MAX_SIZE),
	parameter int QW         = 9 * PIXEL_BITS + 2 * CW + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mf3_pkg::mf3_cfg_t     cfg,
	input  logic                  push,
	output logic                  full,
	input  logic [PIXEL_BITS-1:0] pixel,
	output logic                  q_push,
	input  logic                  q_full,
	output logic [QW-1:0]         q_data
);
	import mf3_pkg::*;

	localparam int NW = CW + 1;

	logic [PIXEL_BITS-1:0] upper_mem [MAX_SIZE];
	logic [PIXEL_BITS-1:0] middle_mem [MAX_SIZE];

	logic [CW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [NW-1:0] n;
	logic [CW-1:0] r_eff;
	logic [CW-1:0] c_eff;
	logic [NW-1:0] c_inc;
	logic [NW-1:0] r_inc;
	logic          in_go;
	logic          s1_go;

	logic                  vld_s1;
	logic                  emit_s1;
	logic                  last_s1;
	logic [CW-1:0]         col_s1;
	logic [CW-1:0]         orow_s1;
	logic [CW-1:0]         ocol_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [PIXEL_BITS-1:0] up_rd_s1;
	logic [PIXEL_BITS-1:0] mid_rd_s1;

	logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] win_q;
	logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] win_nx;

	// clamp the size register to the supported range
	always_comb begin
		if (cfg.size < 8'd3) begin
			n = NW'(3);
		end else if (int'(cfg.size) > MAX_SIZE) begin
			n = NW'(MAX_SIZE);
		end else begin
			n = NW'(cfg.size);
		end
	end

	always_comb begin
		if ({1'b0, row_q} >= n || {1'b0, col_q} >= n) begin
			r_eff = '0;
			c_eff = '0;
		end else begin
			r_eff = row_q;
			c_eff = col_q;
		end
		c_inc = {1'b0, c_eff} + 1'b1;
		r_inc = {1'b0, r_eff} + 1'b1;
	end

	assign s1_go = vld_s1 && (!emit_s1 || !q_full);
	assign full  = vld_s1 && !s1_go;
	assign in_go = push && !full;

	// line buffer reads at accept, write-back once the item leaves the stage
	always_ff @(posedge clk) begin
		if (in_go) begin
			up_rd_s1  <= upper_mem[c_eff];
			mid_rd_s1 <= middle_mem[c_eff];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			upper_mem[col_s1]  <= mid_rd_s1;
			middle_mem[col_s1] <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			pix_s1  <= pixel;
			col_s1  <= c_eff;
			orow_s1 <= r_eff - 1'b1;
			ocol_s1 <= c_eff - 1'b1;
			emit_s1 <= (r_eff >= CW'(2)) && (c_eff >= CW'(2));
			last_s1 <= ({1'b0, r_eff} == n - 1'b1) && ({1'b0, c_eff} == n - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cfg.restart) begin
				row_q <= '0;
				col_q <= '0;
			end else if (in_go) begin
				if (c_inc >= n) begin
					col_q <= '0;
					row_q <= (r_inc >= n) ? '0 : r_inc[CW-1:0];
				end else begin
					col_q <= c_inc[CW-1:0];
					row_q <= r_eff;
				end
			end
			if (in_go) begin
				vld_s1 <= 1'b1;
			end else if (s1_go) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// window shifts left, new column on the right
	always_comb begin
		win_nx[0] = win_q[1];
		win_nx[1] = win_q[2];
		win_nx[2] = up_rd_s1;
		win_nx[3] = win_q[4];
		win_nx[4] = win_q[5];
		win_nx[5] = mid_rd_s1;
		win_nx[6] = win_q[7];
		win_nx[7] = win_q[8];
		win_nx[8] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_go) begin
			win_q <= win_nx;
		end
	end

	assign q_push = s1_go && emit_s1;
	assign q_data = {win_nx, orow_s1, ocol_s1, last_s1};

endmodule

// ----- src/mf3_sort.sv -----
// back: pipelined median-of-nine network with output register
`timescale 1ns / 1ps

module mf3_sort #(
	parameter int PIXEL_BITS = 8,
	parameter int CW         = 7,
	parameter int QW         = 9 * PIXEL_BITS + 2 * CW + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [QW-1:0]         in_data,
	output logic                  empty,
	input  logic                  pop,
	output logic [PIXEL_BITS-1:0] median_value,
	output logic [CW-1:0]         out_row,
	output logic [CW-1:0]         out_col,
	output logic                  last_of_image
);
	import mf3_pkg::*;

	localparam int TW = 2 * CW + 1;

	typedef logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] win_t;

	function automatic win_t cas(input win_t w, input int a, input int b);
		win_t r;
		r = w;
		if (w[a] > w[b]) begin
			r[a] = w[b];
			r[b] = w[a];
		end
		return r;
	endfunction

	win_t          win_in;
	logic [TW-1:0] tag_in;
	win_t          nx1;
	win_t          nx2;
	win_t          nx3;
	win_t          nx4;

	logic                  vld_s1, vld_s2, vld_s3, vld_s4;
	logic                  ld1, ld2, ld3, ld4;
	win_t                  win_s1, win_s2, win_s3;
	logic [TW-1:0]         tag_s1, tag_s2, tag_s3, tag_s4;
	logic [PIXEL_BITS-1:0] med_s4;

	assign win_in = in_data[QW-1:TW];
	assign tag_in = in_data[TW-1:0];

	assign ld4      = !vld_s4 || pop;
	assign ld3      = !vld_s3 || ld4;
	assign ld2      = !vld_s2 || ld3;
	assign ld1      = !vld_s1 || ld2;
	assign in_ready = ld1;

	always_comb begin
		nx1 = cas(cas(cas(win_in, 1, 2), 4, 5), 7, 8);
		nx1 = cas(cas(cas(nx1, 0, 1), 3, 4), 6, 7);
		nx2 = cas(cas(cas(win_s1, 1, 2), 4, 5), 7, 8);
		nx2 = cas(cas(cas(nx2, 0, 3), 5, 8), 4, 7);
		nx3 = cas(cas(cas(win_s2, 3, 6), 1, 4), 2, 5);
		nx3 = cas(nx3, 4, 7);
		nx4 = cas(cas(cas(win_s3, 4, 2), 6, 4), 4, 2);
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			win_s1 <= nx1;
			tag_s1 <= tag_in;
		end
		if (ld2) begin
			win_s2 <= nx2;
			tag_s2 <= tag_s1;
		end
		if (ld3) begin
			win_s3 <= nx3;
			tag_s3 <= tag_s2;
		end
		if (ld4) begin
			med_s4 <= nx4[4];
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (ld1) vld_s1 <= in_valid;
			if (ld2) vld_s2 <= vld_s1;
			if (ld3) vld_s3 <= vld_s2;
			if (ld4) vld_s4 <= vld_s3;
		end
	end

	assign empty         = !vld_s4;
	assign median_value  = med_s4;
	assign out_row       = tag_s4[TW-1:CW+1];
	assign out_col       = tag_s4[CW:1];
	assign last_of_image = tag_s4[0];

endmodule

// ----- src/median_filter_3x3.sv -----
// top level of the streaming 3x3 median filter
`timescale 1ns / 1ps

// Streaming 3x3 median filter over a square image of image_size by image_size pixels
// (clamped to 3..MAX_SIZE), fed in raster order through a push/full queue port. One
// pixel is taken every clock cycle for as long as results are popped; for each interior
// position a result with its row, column and last-of-image flag reaches the result
// ports after the transfer of the pixel below and to the right of it: the front
// register (line buffer read and window shift) loads on that transfer, then the item
// passes the decoupling queue and the sorting network. Border positions give no
// result. The line buffers are single-entry-per-cycle
// memories with registered reads, read at the column of the accepted pixel and written
// back as that pixel leaves the front; they have no reset and need no clearing pass,
// since never-written entries only reach border positions. Writing image_size restarts
// the image at row 0, column 0 and keeps the line buffer contents; write it only while
// the block is idle.

module median_filter_3x3 #(
	parameter int MAX_SIZE   = mf3_pkg::MAX_SIZE_DEF,
	parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF,
	parameter int CW         = $clog2(MAX_SIZE)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mf3_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// pixel input
	input  logic                          push,
	output logic                          full,
	input  logic [PIXEL_BITS-1:0]         pixel,
	// result output
	output logic                          empty,
	input  logic                          pop,
	output logic [PIXEL_BITS-1:0]         median_value,
	output logic [CW-1:0]                 out_row,
	output logic [CW-1:0]                 out_col,
	output logic                          last_of_image
);
	import mf3_pkg::*;

	// queue item: nine window taps, output row and column, last flag
	localparam int QW = WIN_TAPS * PIXEL_BITS + 2 * CW + 1;

	logic [SIZE_BITS-1:0] size_q;
	logic                 cfg_wr;
	mf3_cfg_t             cfg;

	logic          fq_push;
	logic          fq_full;
	logic [QW-1:0] fq_wdata;
	logic          fq_valid;
	logic          fq_pop;
	logic [QW-1:0] fq_rdata;

	// register write on the access phase of a transfer
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[ADDR_BITS-1:2] == REG_IMAGE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_wr) begin
			size_q <= pwdata[SIZE_BITS-1:0];
		end
	end

	// read-back of the size register, zero elsewhere
	always_comb begin
		if (paddr[ADDR_BITS-1:2] == REG_IMAGE_SIZE) begin
			prdata = {{(32 - SIZE_BITS){1'b0}}, size_q};
		end else begin
			prdata = '0;
		end
	end

	// restart pulse travels with the size so the counters clear on the write
	assign cfg.restart = cfg_wr;
	assign cfg.size    = size_q;

	// front: counters, line buffers, window
	mf3_front #(
		.MAX_SIZE  (MAX_SIZE),
		.PIXEL_BITS(PIXEL_BITS),
		.CW        (CW),
		.QW        (QW)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.push  (push),
		.full  (full),
		.pixel (pixel),
		.q_push(fq_push),
		.q_full(fq_full),
		.q_data(fq_wdata)
	);

	// decoupling queue so front and sorter stall independently
	mf3_queue #(
		.W    (QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.full   (fq_full),
		.wr_data(fq_wdata),
		.pop    (fq_pop),
		.valid  (fq_valid),
		.rd_data(fq_rdata)
	);

	// back: median network, last stage is the output register
	mf3_sort #(
		.PIXEL_BITS(PIXEL_BITS),
		.CW        (CW),
		.QW        (QW)
	) u_sort (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (fq_valid),
		.in_ready     (fq_pop),
		.in_data      (fq_rdata),
		.empty        (empty),
		.pop          (pop),
		.median_value (median_value),
		.out_row      (out_row),
		.out_col      (out_col),
		.last_of_image(last_of_image)
	);

endmodule
